### rtl/positional_list_store_macros.svh
// ----------------------------------------------------------------------------
// positional_list_store_macros
// Assertion macros used by the positional list store top level.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define PLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_store: assertion failed");

// Next-cycle implication, checked on clk, off during reset.
`define PLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_store: assertion failed");

`endif

### rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types, codes and widths shared by the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 2;
  localparam int POS_W     = 16;
  localparam int VAL_W     = 64;
  localparam int ST_W      = 2;
  localparam int IN_W      = 80;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic [ST_W-1:0]  status;
  } res_t;

endpackage

### rtl/pls_engine.sv
// ----------------------------------------------------------------------------
// pls_engine
// Element memory and shift sequencer: elements are moved one at a time
// through a single write port and a registered read port.
// ----------------------------------------------------------------------------
module pls_engine #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  pls_pkg::cmd_t                cmd,
  output logic                         res_valid,
  input  logic                         res_ready,
  output pls_pkg::res_t                res,
  output logic [$clog2(DEPTH+1)-1:0]   res_len
);
  import pls_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_REM_CP = 3'd3;
  localparam logic [2:0] S_REM    = 3'd4;
  localparam logic [2:0] S_REM_WR = 3'd5;
  localparam logic [2:0] S_RD_CP  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_q;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] data_r, data_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic [VAL_W-1:0] mem_wd;

  logic [POS_W-1:0] cnt_ext;
  logic [POS_W-1:0] last_ext;
  logic [AW-1:0]    ins_pos;
  logic [AW-1:0]    rem_pos;
  logic             full;

  assign full     = (cnt_r == CW'(DEPTH));
  assign cnt_ext  = POS_W'(cnt_r);
  assign last_ext = POS_W'(cnt_r - CW'(1));
  assign ins_pos  = (cmd.pos > cnt_ext) ? cnt_r[AW-1:0] : cmd.pos[AW-1:0];
  assign rem_pos  = (cmd.pos > last_ext) ? last_ext[AW-1:0] : cmd.pos[AW-1:0];

  assign cmd_ready  = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.data   = data_r;
  assign res.status = st_r;
  assign res_len    = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    data_nxt  = data_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = rd_q;
    mem_ra    = idx_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          data_nxt = '0;
          val_nxt  = cmd.value;
          st_nxt   = ST_OK;
          case (cmd.op)
            OP_INSERT: begin
              if (full) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = cnt_r[AW-1:0];
                pos_nxt   = ins_pos;
                state_nxt = S_INS;
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                mem_ra    = rem_pos;
                idx_nxt   = rem_pos;
                state_nxt = S_REM_CP;
              end
            end
            OP_READ: begin
              if (cmd.pos >= cnt_ext) begin
                st_nxt    = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                mem_ra    = cmd.pos[AW-1:0];
                state_nxt = S_RD_CP;
              end
            end
            default: begin
              st_nxt    = ST_RANGE;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS: begin
        if (idx_r == pos_r) begin
          mem_we    = 1'b1;
          mem_wd    = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_ra    = idx_r - AW'(1);
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_r - AW'(1);
        state_nxt = S_INS;
      end
      S_REM_CP: begin
        data_nxt  = rd_q;
        state_nxt = S_REM;
      end
      S_REM: begin
        if ((CW+1)'(idx_r) + (CW+1)'(1) < (CW+1)'(cnt_r)) begin
          mem_ra    = idx_r + AW'(1);
          state_nxt = S_REM_WR;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_r + AW'(1);
        state_nxt = S_REM;
      end
      S_RD_CP: begin
        data_nxt  = rd_q;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    data_r <= data_nxt;
    st_r   <= st_nxt;
  end

endmodule

### rtl/positional_list_store.sv
// Path from input transfer to out_tvalid: the engine sequencer, then the output register;
//   insert and remove shift the elements from the position on, one at a time.
// Throughput: one command at a time; the element memory, with one write port and a
//   registered read port, moves one element at a time.
// Reset: synchronous, active low; clears the element count, the sequencer and
//   the output valid; element memory is left as is and needs no clearing pass.
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 64-bit values with insert, remove and read by position.
// ----------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module positional_list_store #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // position [15:0], value [79:16]
  input  logic [pls_pkg::IN_W-1:0]                    in_tdata,
  // operation [1:0]
  input  logic [pls_pkg::OP_W-1:0]                    in_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // data [63:0], length [63+clog2(DEPTH+1):64], zero fill above
  output logic [((pls_pkg::VAL_W+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata,
  // status [1:0]
  output logic [pls_pkg::ST_W-1:0]                    out_tuser
);
  import pls_pkg::*;

  localparam int CW    = $clog2(DEPTH+1);
  localparam int OUT_W = ((VAL_W + CW + 7) / 8) * 8;

  cmd_t          cmd;
  res_t          res;
  logic          cmd_ready;
  logic          res_valid;
  logic          res_ready;
  logic [CW-1:0] res_len;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_data_r;
  logic [CW-1:0]    out_len_r;
  logic [ST_W-1:0]  out_st_r;

  assign cmd.op    = in_tuser;
  assign cmd.pos   = in_tdata[POS_W-1:0];
  assign cmd.value = in_tdata[POS_W +: VAL_W];
  assign in_tready = cmd_ready;

  pls_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .res_len   (res_len)
  );

  // load the output stage when empty or draining this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res.data;
      out_len_r  <= res_len;
      out_st_r   <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_len_r, out_data_r});
  assign out_tuser  = out_st_r;

  `PLS_ASSERT_NXT(a_busy_after_cmd, in_tvalid && in_tready, !in_tready)
  `PLS_ASSERT_IMP(a_len_bound, 1'b1, res_len <= CW'(DEPTH))
  `PLS_ASSERT_IMP(a_full_len, out_tvalid && out_st_r == ST_FULL, out_len_r == CW'(DEPTH))
  `PLS_ASSERT_IMP(a_fail_zero, out_tvalid && out_st_r != ST_OK, out_data_r == '0)

endmodule
